>>> rtl/fbfla_pkg.sv
// Package for the fixed-size block free-list allocator.
// Holds pool constants, status and operation codes, register indexes and the block-size function.
// No dependencies; used by fixed_block_free_list_allocator_core and its testbench.
package fbfla_pkg;

    // Pool geometry and size rounding.
    localparam int POOL_BLOCKS     = 1024;
    localparam int ALIGN_BYTES     = 16;
    localparam int MIN_BLOCK_BYTES = 8;

    // Field widths of the request, the response and the registers.
    localparam int IDX_W   = 10;
    localparam int OFF_W   = 26;
    localparam int REQB_W  = 17;
    localparam int STEP_W  = 11;
    localparam int STAT_W  = 2;

    // Derived widths of the internal state.
    localparam int PTR_W   = $clog2(POOL_BLOCKS);
    localparam int CNT_W   = $clog2(POOL_BLOCKS + 1);
    localparam int LINK_W  = PTR_W + 1;

    // Operation codes.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_ALLOC    = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM      = 2'd1;
    localparam logic [STAT_W-1:0] ST_RELEASED = 2'd2;
    localparam logic [STAT_W-1:0] ST_NULL     = 2'd3;

    // Register indexes.
    localparam logic REG_BLOCK_BYTES = 1'b0;
    localparam logic REG_EXPAND_STEP = 1'b1;

    // Raise the requested size to the minimum, then round up to the alignment.
    // The result is one bit wider than the request, since the largest request rounds past it.
    function automatic logic [REQB_W:0] block_bytes(input logic [REQB_W-1:0] req);
        logic [REQB_W:0] sz;
        sz  = (req < REQB_W'(MIN_BLOCK_BYTES)) ? (REQB_W+1)'(MIN_BLOCK_BYTES)
                                               : {1'b0, req};
        return (REQB_W+1)'((sz + (REQB_W+1)'(ALIGN_BYTES - 1)) / ALIGN_BYTES * ALIGN_BYTES);
    endfunction

endpackage

>>> rtl/fbfla_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the next-pointer store of the allocator; depends on no package.
module fbfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fixed_block_free_list_allocator_core.sv
// Fixed-size block allocator: a linked free list kept in a next-pointer RAM, with a head register.
// Depends on fbfla_pkg and fbfla_ram.
//
// One request is worked on at a time. A release or a null release goes from idle straight
// to the response state, an allocate from a non-empty list passes a pop state that waits on the
// registered read of the next-pointer RAM, and an allocate that expands the list by more than
// one block walks a carve state that writes one link into the RAM per cycle. The response sits
// in an output register, so a new request is taken while the previous response waits. The
// next-pointer RAM needs no clearing after reset: a pop only reads links that a push wrote.
module fixed_block_free_list_allocator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Request channel.
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  logic                              i_operation,
    input  logic [fbfla_pkg::IDX_W-1:0]       i_release_index,
    input  logic                              i_release_is_null,
    // Response channel.
    output logic                              o_rsp_valid,
    input  logic                              i_rsp_ready,
    output logic [fbfla_pkg::STAT_W-1:0]      o_status,
    output logic [fbfla_pkg::IDX_W-1:0]       o_block_index,
    output logic [fbfla_pkg::OFF_W-1:0]       o_byte_offset
);

    localparam int PW = fbfla_pkg::PTR_W;
    localparam int CW = fbfla_pkg::CNT_W;
    localparam int LW = fbfla_pkg::LINK_W;
    localparam int SW = fbfla_pkg::STEP_W;
    localparam int BW = fbfla_pkg::REQB_W;
    localparam int IW = fbfla_pkg::IDX_W;
    localparam int MW = IW + BW + 1;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_CARVE = 2'd2;
    localparam logic [1:0] S_RES   = 2'd3;

    logic [1:0]                     r_state,   n_state;
    logic [PW-1:0]                  r_head,    n_head;
    logic                           r_empty,   n_empty;
    logic [CW-1:0]                  r_carved,  n_carved;
    logic [PW-1:0]                  r_walk,    n_walk;
    logic [PW-1:0]                  r_end,     n_end;
    logic [fbfla_pkg::STAT_W-1:0]   r_res_st,  n_res_st;
    logic [IW-1:0]                  r_res_idx, n_res_idx;
    logic                           r_out_valid;
    logic [fbfla_pkg::STAT_W-1:0]   r_out_st;
    logic [IW-1:0]                  r_out_idx;
    logic [fbfla_pkg::OFF_W-1:0]    r_out_off;
    logic [BW-1:0]                  r_req_bytes;
    logic [SW-1:0]                  r_step;
    logic [BW:0]                    r_bsize;

    logic                           cfg_wr;
    logic                           req_acc;
    logic                           out_load;
    logic [SW-1:0]                  step;
    logic                           step_fits;
    logic [MW-1:0]                  product;

    logic                           ram_we;
    logic [PW-1:0]                  ram_waddr;
    logic [LW-1:0]                  ram_wdata;
    logic                           ram_re;
    logic [LW-1:0]                  ram_rdata;

    // Next-pointer store: each entry holds the end-of-list flag over the next index.
    fbfla_ram #(
        .WIDTH (LW),
        .DEPTH (fbfla_pkg::POOL_BLOCKS)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // Configuration writes and readback.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            fbfla_pkg::REG_BLOCK_BYTES: prdata = 32'(r_req_bytes);
            fbfla_pkg::REG_EXPAND_STEP: prdata = 32'(r_step);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_bytes <= BW'(16);
            r_bsize     <= fbfla_pkg::block_bytes(BW'(16));
            r_step      <= SW'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == fbfla_pkg::REG_BLOCK_BYTES) begin
                r_req_bytes <= pwdata[BW-1:0];
                r_bsize     <= fbfla_pkg::block_bytes(pwdata[BW-1:0]);
            end else begin
                r_step <= pwdata[SW-1:0];
            end
        end
    end

    // Handshake and expansion sizing.
    assign o_req_ready = (r_state == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;
    assign out_load    = (r_state == S_RES) && (!r_out_valid || i_rsp_ready);
    assign step        = (r_step == '0) ? SW'(1) : r_step;
    assign step_fits   = ((CW+1)'(r_carved) + (CW+1)'(step))
                         <= (CW+1)'(fbfla_pkg::POOL_BLOCKS);

    // Sequencer: pop, push, expansion walk and response hand-off.
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_empty   = r_empty;
        n_carved  = r_carved;
        n_walk    = r_walk;
        n_end     = r_end;
        n_res_st  = r_res_st;
        n_res_idx = r_res_idx;
        ram_we    = 1'b0;
        ram_waddr = r_walk;
        ram_wdata = {1'b0, r_walk - PW'(1)};
        ram_re    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_res_idx = '0;
                    n_state   = S_RES;
                    if (i_operation == fbfla_pkg::OP_RELEASE) begin
                        if (i_release_is_null) begin
                            n_res_st = fbfla_pkg::ST_NULL;
                        end else begin
                            n_res_st = fbfla_pkg::ST_RELEASED;
                            if (32'(i_release_index) < fbfla_pkg::POOL_BLOCKS) begin
                                ram_we    = 1'b1;
                                ram_waddr = PW'(i_release_index);
                                ram_wdata = {r_empty, r_head};
                                n_head    = PW'(i_release_index);
                                n_empty   = 1'b0;
                            end
                        end
                    end else if (!r_empty) begin
                        ram_re  = 1'b1;
                        n_state = S_POP;
                    end else if (!step_fits) begin
                        n_res_st = fbfla_pkg::ST_OOM;
                    end else begin
                        // First carved block ends the list.
                        ram_we    = 1'b1;
                        ram_waddr = r_carved[PW-1:0];
                        ram_wdata = {1'b1, r_head};
                        if (step == SW'(1)) begin
                            n_res_st  = fbfla_pkg::ST_ALLOC;
                            n_res_idx = IW'(r_carved[PW-1:0]);
                            n_carved  = r_carved + CW'(1);
                        end else begin
                            n_walk  = r_carved[PW-1:0] + PW'(1);
                            n_end   = PW'(r_carved + CW'(step) - CW'(1));
                            n_state = S_CARVE;
                        end
                    end
                end
            end
            S_POP: begin
                n_head    = ram_rdata[PW-1:0];
                n_empty   = ram_rdata[PW];
                n_res_st  = fbfla_pkg::ST_ALLOC;
                n_res_idx = IW'(r_head);
                n_state   = S_RES;
            end
            S_CARVE: begin
                if (r_walk == r_end) begin
                    // The highest carved block is handed out at once.
                    n_head    = r_end - PW'(1);
                    n_empty   = 1'b0;
                    n_carved  = CW'(r_end) + CW'(1);
                    n_res_st  = fbfla_pkg::ST_ALLOC;
                    n_res_idx = IW'(r_end);
                    n_state   = S_RES;
                end else begin
                    ram_we = 1'b1;
                    n_walk = r_walk + PW'(1);
                end
            end
            S_RES: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_empty  <= 1'b1;
            r_carved <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_empty  <= n_empty;
            r_carved <= n_carved;
        end
    end

    // Walk pointers and pending response need no reset.
    always_ff @(posedge i_clk) begin
        r_walk    <= n_walk;
        r_end     <= n_end;
        r_res_st  <= n_res_st;
        r_res_idx <= n_res_idx;
    end

    // Output register: the offset multiply lands directly in it.
    assign product = MW'(r_res_idx) * MW'(r_bsize);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_st  <= r_res_st;
            r_out_idx <= r_res_idx;
            r_out_off <= product[fbfla_pkg::OFF_W-1:0];
        end
    end

    assign o_rsp_valid   = r_out_valid;
    assign o_status      = r_out_st;
    assign o_block_index = r_out_idx;
    assign o_byte_offset = r_out_off;

endmodule

>>> verif/tb_fixed_block_free_list_allocator_core.sv
// Self-checking testbench for fixed_block_free_list_allocator_core.
// Holds a free-list predictor, request driver, response checker and the test sequence.
// Depends on fbfla_pkg and the allocator RTL.
module tb_fixed_block_free_list_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 40;

    typedef struct {
        logic [fbfla_pkg::STAT_W-1:0] status;
        logic [fbfla_pkg::IDX_W-1:0]  block;
        logic [fbfla_pkg::OFF_W-1:0]  offset;
    } t_alloc_response;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [2:0]                   paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         i_req_valid;
    logic                         o_req_ready;
    logic                         i_operation;
    logic [fbfla_pkg::IDX_W-1:0]  i_release_index;
    logic                         i_release_is_null;
    logic                         o_rsp_valid;
    logic                         i_rsp_ready;
    logic [fbfla_pkg::STAT_W-1:0] o_status;
    logic [fbfla_pkg::IDX_W-1:0]  o_block_index;
    logic [fbfla_pkg::OFF_W-1:0]  o_byte_offset;

    // Shadow of the allocator: links, head, empty flag, carve count and registers.
    logic [fbfla_pkg::PTR_W-1:0]  link_next [fbfla_pkg::POOL_BLOCKS];
    logic                         link_last [fbfla_pkg::POOL_BLOCKS];
    logic [fbfla_pkg::PTR_W-1:0]  free_head_q;
    logic                         free_list_empty;
    logic [fbfla_pkg::CNT_W-1:0]  blocks_carved;
    logic [fbfla_pkg::REQB_W-1:0] cfg_block_bytes;
    logic [fbfla_pkg::STEP_W-1:0] cfg_expand_step;

    t_alloc_response              awaited_responses [$];
    logic [fbfla_pkg::IDX_W-1:0]  held_blocks [$];

    int mismatches      = 0;
    int cycle_count     = 0;
    int req_idle_pct    = 22;
    int rsp_stall_pct   = 22;
    int settings_used   = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    fixed_block_free_list_allocator_core u_top (.*);

    always #1 i_clk = ~i_clk;

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d responses outstanding.",
                     cycle_count, awaited_responses.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Block size after the minimum and the alignment are applied.
    function automatic int unsigned aligned_size(input logic [fbfla_pkg::REQB_W-1:0] req);
        int unsigned sz;
        sz = (int'(req) < fbfla_pkg::MIN_BLOCK_BYTES) ? fbfla_pkg::MIN_BLOCK_BYTES : int'(req);
        return ((sz + fbfla_pkg::ALIGN_BYTES - 1) / fbfla_pkg::ALIGN_BYTES)
               * fbfla_pkg::ALIGN_BYTES;
    endfunction

    function automatic void push_free_block(input logic [fbfla_pkg::PTR_W-1:0] idx);
        link_next[idx]  = free_head_q;
        link_last[idx]  = free_list_empty;
        free_head_q     = idx;
        free_list_empty = 1'b0;
    endfunction

    // Advance the shadow state by one request and return the response it causes.
    function automatic t_alloc_response predict_request(
        input logic                        op,
        input logic [fbfla_pkg::IDX_W-1:0] idx,
        input logic                        is_null);
        t_alloc_response             resp;
        int                          step;
        logic [fbfla_pkg::PTR_W-1:0] got;
        resp = '{status: fbfla_pkg::ST_OOM, block: '0, offset: '0};
        if (op == fbfla_pkg::OP_ALLOC) begin
            // An empty list is refilled first, lowest index pushed first.
            if (free_list_empty) begin
                step = (cfg_expand_step == 0) ? 1 : int'(cfg_expand_step);
                if (int'(blocks_carved) + step <= fbfla_pkg::POOL_BLOCKS) begin
                    for (int k = 0; k < step; k++) begin
                        push_free_block(fbfla_pkg::PTR_W'(int'(blocks_carved) + k));
                    end
                    blocks_carved = fbfla_pkg::CNT_W'(int'(blocks_carved) + step);
                end
            end
            if (!free_list_empty) begin
                got             = free_head_q;
                free_list_empty = link_last[got];
                free_head_q     = link_next[got];
                resp.status     = fbfla_pkg::ST_ALLOC;
                resp.block      = got;
                resp.offset     = fbfla_pkg::OFF_W'(longint'(got)
                                  * longint'(aligned_size(cfg_block_bytes)));
            end
        end else if (is_null) begin
            resp.status = fbfla_pkg::ST_NULL;
        end else begin
            push_free_block(idx);
            resp.status = fbfla_pkg::ST_RELEASED;
        end
        return resp;
    endfunction

    // Compare every accepted response with the oldest prediction.
    always @(posedge i_clk) begin : response_check
        t_alloc_response want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (awaited_responses.size() == 0) begin
                report_mismatch($sformatf("response with none awaited: status %0d block %0d",
                                          o_status, o_block_index));
            end else begin
                want = awaited_responses.pop_front();
                status_seen[want.status]++;
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                end
                if (o_block_index !== want.block) begin
                    report_mismatch($sformatf("block index %0d, expected %0d",
                                              o_block_index, want.block));
                end
                if (o_byte_offset !== want.offset) begin
                    report_mismatch($sformatf("byte offset %0d, expected %0d",
                                              o_byte_offset, want.offset));
                end
            end
        end
        i_rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    // Send one request, record its prediction, then maybe leave a gap.
    task automatic issue_request(input logic op, input logic [fbfla_pkg::IDX_W-1:0] idx,
                                 input logic is_null, output t_alloc_response resp);
        i_req_valid       <= 1'b1;
        i_operation       <= op;
        i_release_index   <= idx;
        i_release_is_null <= is_null;
        do @(posedge i_clk); while (!o_req_ready);
        resp = predict_request(op, idx, is_null);
        awaited_responses.push_back(resp);
        if ($urandom_range(0, 99) < req_idle_pct) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Allocate with random content in the fields that an allocate ignores.
    task automatic request_alloc(output t_alloc_response resp);
        issue_request(fbfla_pkg::OP_ALLOC,
                      fbfla_pkg::IDX_W'($urandom_range(0, fbfla_pkg::POOL_BLOCKS - 1)),
                      1'($urandom_range(0, 1)), resp);
    endtask

    task automatic request_release(input logic [fbfla_pkg::IDX_W-1:0] idx,
                                   input logic is_null);
        t_alloc_response resp;
        issue_request(fbfla_pkg::OP_RELEASE, idx, is_null, resp);
    endtask

    // Stop sending and let every awaited response arrive.
    task automatic wait_until_idle();
        i_req_valid <= 1'b0;
        while (awaited_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_register(input logic reg_idx, input logic [31:0] want);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            report_mismatch($sformatf("register %0d reads %0d, expected %0d",
                                      reg_idx, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a register, mirror it in the shadow and read it back.
    task automatic write_register(input logic reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == fbfla_pkg::REG_BLOCK_BYTES) begin
            cfg_block_bytes = value[fbfla_pkg::REQB_W-1:0];
        end else begin
            cfg_expand_step = value[fbfla_pkg::STEP_W-1:0];
        end
        @(posedge i_clk);
        check_register(reg_idx, (reg_idx == fbfla_pkg::REG_BLOCK_BYTES)
                                ? 32'(cfg_block_bytes) : 32'(cfg_expand_step));
    endtask

    task automatic apply_settings(input int unsigned block_bytes_req, input int unsigned step);
        write_register(fbfla_pkg::REG_BLOCK_BYTES, block_bytes_req);
        write_register(fbfla_pkg::REG_EXPAND_STEP, step);
        settings_used++;
    endtask

    task automatic test_reset_values();
        check_register(fbfla_pkg::REG_BLOCK_BYTES, 32'(cfg_block_bytes));
        check_register(fbfla_pkg::REG_EXPAND_STEP, 32'(cfg_expand_step));
    endtask

    // Carving one block at a time, pops, pushes, LIFO order and a null release.
    task automatic test_basic_requests();
        t_alloc_response resp;
        request_alloc(resp);
        request_alloc(resp);
        request_release(fbfla_pkg::IDX_W'(0), 1'b0);
        request_release(fbfla_pkg::IDX_W'(fbfla_pkg::POOL_BLOCKS - 1), 1'b1);
        request_alloc(resp);
        request_alloc(resp);
        request_release(fbfla_pkg::IDX_W'(1), 1'b0);
        request_release(fbfla_pkg::IDX_W'(2), 1'b0);
        request_alloc(resp);
        request_alloc(resp);
    endtask

    // Size rounding of zero and large requests, zero and multi-block steps, and running out of carve room.
    task automatic test_sizes_and_steps();
        t_alloc_response resp;
        wait_until_idle();
        apply_settings(0, 0);
        request_alloc(resp);
        wait_until_idle();
        apply_settings(65536, 4);
        request_alloc(resp);
        request_alloc(resp);
        wait_until_idle();
        apply_settings(17, 1024);
        request_alloc(resp);
        request_alloc(resp);
        request_alloc(resp);
        request_release(fbfla_pkg::IDX_W'(5), 1'b0);
        request_alloc(resp);
        wait_until_idle();
        apply_settings(1, 1);
        // A block that was never carved is pushed all the same.
        request_release(fbfla_pkg::IDX_W'(1000), 1'b0);
        request_alloc(resp);
        request_alloc(resp);
        request_release('0, 1'b1);
    endtask

    // Phases of random settings and random alloc and release mixes.
    task automatic test_random_traffic();
        t_alloc_response             resp;
        int                          alloc_pct;
        int                          roll;
        int                          pick;
        int unsigned                 req_bytes;
        int unsigned                 step;
        logic [fbfla_pkg::IDX_W-1:0] idx;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_until_idle();
            case ($urandom_range(0, 5))
                0:       req_bytes = 0;
                1:       req_bytes = 65536;
                2:       req_bytes = $urandom_range(1, 16);
                3:       req_bytes = $urandom_range(17, 256);
                default: req_bytes = $urandom_range(0, 65536);
            endcase
            case ($urandom_range(0, 7))
                0:       step = 0;
                1:       step = 1;
                5:       step = $urandom_range(17, 128);
                6:       step = $urandom_range(129, 600);
                7:       step = 1024;
                default: step = $urandom_range(2, 16);
            endcase
            apply_settings(req_bytes, step);
            // One phase runs back to back on both sides.
            req_idle_pct  = (phase == 2) ? 0 : 22;
            rsp_stall_pct = (phase == 2) ? 0 : 22;
            alloc_pct     = $urandom_range(50, 90);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    request_release(
                        fbfla_pkg::IDX_W'($urandom_range(0, fbfla_pkg::POOL_BLOCKS - 1)), 1'b1);
                end else if (roll < alloc_pct || held_blocks.size() == 0) begin
                    request_alloc(resp);
                    if (resp.status == fbfla_pkg::ST_ALLOC) held_blocks.push_back(resp.block);
                end else begin
                    pick = $urandom_range(0, held_blocks.size() - 1);
                    idx  = held_blocks[pick];
                    held_blocks.delete(pick);
                    request_release(idx, 1'b0);
                end
            end
        end
        req_idle_pct  = 22;
        rsp_stall_pct = 22;
    endtask

    // Carve whatever is left, drain the list, then hit out of memory and recover.
    task automatic test_pool_exhaustion();
        t_alloc_response resp;
        wait_until_idle();
        apply_settings(cfg_block_bytes,
                       (int'(blocks_carved) < fbfla_pkg::POOL_BLOCKS)
                       ? fbfla_pkg::POOL_BLOCKS - blocks_carved : 0);
        // The drain is the long stretch without idling on either side.
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        while (!(free_list_empty && int'(blocks_carved) == fbfla_pkg::POOL_BLOCKS)) begin
            request_alloc(resp);
            if (resp.status == fbfla_pkg::ST_ALLOC) held_blocks.push_back(resp.block);
        end
        req_idle_pct  = 22;
        rsp_stall_pct = 22;
        request_alloc(resp);
        wait_until_idle();
        apply_settings(cfg_block_bytes, 0);
        request_alloc(resp);
        repeat (3) request_release(held_blocks.pop_back(), 1'b0);
        repeat (3) begin
            request_alloc(resp);
            if (resp.status == fbfla_pkg::ST_ALLOC) held_blocks.push_back(resp.block);
        end
    endtask

    // Releasing one block twice leaves a cycle, so it keeps coming back.
    task automatic test_repeated_release();
        t_alloc_response             resp;
        logic [fbfla_pkg::IDX_W-1:0] idx;
        idx = held_blocks.pop_back();
        request_release(idx, 1'b0);
        request_release(idx, 1'b0);
        repeat (4) request_alloc(resp);
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        i_req_valid       <= 1'b0;
        i_operation       <= fbfla_pkg::OP_ALLOC;
        i_release_index   <= '0;
        i_release_is_null <= 1'b0;
        i_rsp_ready       <= 1'b0;
        free_head_q     = '0;
        free_list_empty = 1'b1;
        blocks_carved   = '0;
        cfg_block_bytes = fbfla_pkg::REQB_W'(16);
        cfg_expand_step = fbfla_pkg::STEP_W'(1);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_basic_requests();
        test_sizes_and_steps();
        test_random_traffic();
        test_pool_exhaustion();
        test_repeated_release();

        // Drain, then watch a little longer for stray responses.
        wait_until_idle();
        repeat (20) @(posedge i_clk);
        $display("Responses checked: %0d allocated, %0d out of memory, %0d released, %0d null.",
                 status_seen[fbfla_pkg::ST_ALLOC], status_seen[fbfla_pkg::ST_OOM],
                 status_seen[fbfla_pkg::ST_RELEASED], status_seen[fbfla_pkg::ST_NULL]);
        $display("Register settings used: %0d; blocks carved: %0d of %0d; mismatches: %0d.",
                 settings_used, blocks_carved, fbfla_pkg::POOL_BLOCKS, mismatches);
        if (mismatches == 0 && awaited_responses.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
